FILE: src/spq_pkg.sv
package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic
    {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } req_type_t;

    typedef enum logic [1:0]
    {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_COMPARE,
        S_COMMIT
    } state_t;

    // Sequencing strobes from the controller.
    typedef struct packed
    {
        logic cmp;
        logic commit;
    } ctrl_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed
    {
        logic cmp;
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

FILE: src/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  data_t     req_value,
    input  data_t     left_entry,
    input  logic      left_shift,
    input  data_t     right_entry,
    output data_t     entry,
    output data_t     entry_next,
    output logic      ins_shift,
    output logic      match
);

    data_t entry_reg;
    logic  ge_reg;
    logic  free_reg;
    logic  match_reg;

    // An empty cell always takes part in an insert shift; together with the
    // descending order this keeps the shift flags monotone along the row.
    assign ins_shift = ge_reg | free_reg;
    assign match     = match_reg;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_shift)
                entry_next = left_entry;
            else if (ins_shift)
                entry_next = req_value;
        end
        else if (cmd.del)
        begin
            if (ge_reg)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg    <= 1'b0;
            free_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (cmd.cmp)
        begin
            ge_reg    <= occupied && (req_value >= entry_reg);
            free_reg  <= !occupied;
            match_reg <= occupied && (req_value == entry_reg);
        end
    end

endmodule

FILE: src/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        ctrl.cmp    = 1'b0;
        ctrl.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_COMPARE:
            begin
                ctrl.cmp = 1'b1;
            end
            S_COMMIT:
            begin
                ctrl.commit = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.commit)
            rsp_valid_next = 1'b1;
        else
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // A response is loaded only from the commit state.
    a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> state_reg == S_COMMIT)
        else $error("commit outside commit state");

    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> rsp_valid_reg)
        else $error("committed request has no response");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !ctrl.commit)
        else $error("pending response overwritten");

endmodule

FILE: src/sorted_priority_queue.sv
// Channel   | Signals                                | Direction
// ----------+----------------------------------------+----------
// request   | req_valid, req_ready, req_type, value  | in
// response  | rsp_valid, rsp_ready, status,          | out
//           | entry_count, head_value                |
//
// Each request passes three steps: accept, a compare step in which every cell
// checks its entry against the value, and a commit step where the affected cells
// shift with their neighbors. A new request is taken once the previous one has
// committed. Reset empties the queue at once; no clearing pass is needed.
// A response waiting on rsp_ready holds the commit step, and with it the queue.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_type_t                req_type,
    input  data_t                    value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output status_t                  status,
    output logic [ENTRY_COUNT_W-1:0] entry_count,
    output data_t                    head_value
);

    localparam int CW = $clog2(DEPTH + 1);

    ctrl_t     ctrl;
    cell_cmd_t cmd;

    req_type_t req_type_reg;
    data_t     value_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    status_t                  status_reg;
    status_t                  status_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    data_t                    head_reg;

    data_t entry_vec      [DEPTH];
    data_t entry_next_vec [DEPTH];
    logic  [DEPTH-1:0] shift_vec;
    logic  [DEPTH-1:0] match_vec;

    logic is_ins;
    logic full;
    logic empty;
    logic found;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    assign is_ins = (req_type_reg == REQ_INSERT);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign found  = |match_vec;

    assign cmd.cmp = ctrl.cmp;
    assign cmd.ins = ctrl.commit && is_ins && !full;
    assign cmd.del = ctrl.commit && !is_ins && found;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            data_t left_entry;
            logic  left_shift;
            data_t right_entry;

            if (i == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_shift = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = entry_vec[i-1];
                assign left_shift = shift_vec[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_body
                assign right_entry = entry_vec[i+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .occupied    (CW'(i) < count_reg),
                .req_value   (value_reg),
                .left_entry  (left_entry),
                .left_shift  (left_shift),
                .right_entry (right_entry),
                .entry       (entry_vec[i]),
                .entry_next  (entry_next_vec[i]),
                .ins_shift   (shift_vec[i]),
                .match       (match_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        else if (cmd.del)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        if (is_ins)
            status_next = full ? ST_FULL : ST_DONE;
        else if (empty)
            status_next = ST_EMPTY;
        else
            status_next = found ? ST_DONE : ST_NOT_FOUND;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_type_reg <= req_type;
            value_reg    <= value;
        end
        if (ctrl.commit)
        begin
            status_reg      <= status_next;
            entry_count_reg <= ENTRY_COUNT_W'(count_next);
            head_reg        <= (count_next != '0) ? entry_next_vec[0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign head_value  = head_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.commit && status_next != ST_DONE) |=> count_reg == $past(count_reg))
        else $error("refused request changed the count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.del))
        else $error("insert and delete in the same cycle");

endmodule

FILE: tb/sv/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_ready,
    input  req_type_t                req_type,
    input  data_t                    value,
    input  logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  status_t                  status,
    input  logic [ENTRY_COUNT_W-1:0] entry_count,
    input  data_t                    head_value,
    output int                       fail_count,
    output int                       pending_count
);

    typedef struct packed
    {
        status_t                  status;
        logic [ENTRY_COUNT_W-1:0] count;
        data_t                    head;
    } queue_response_t;

    // Mirror of the queue contents, kept in descending order.
    data_t           sorted_entries [DEPTH];
    int              sorted_count = 0;
    int              error_total  = 0;
    queue_response_t expected_responses [$];

    assign fail_count = error_total;

    function automatic queue_response_t apply_request(input req_type_t kind, input data_t v);
        queue_response_t resp;
        int              pos;
        if (kind == REQ_INSERT) begin
            if (sorted_count >= DEPTH) begin
                resp.status = ST_FULL;
            end
            else begin
                // A new value goes ahead of any equal values already stored.
                pos = sorted_count;
                for (int j = 0; j < sorted_count; j++)
                begin
                    if (pos == sorted_count && v >= sorted_entries[j])
                        pos = j;
                end
                for (int j = sorted_count; j > pos; j--)
                begin
                    sorted_entries[j] = sorted_entries[j-1];
                end
                sorted_entries[pos] = v;
                sorted_count++;
                resp.status = ST_DONE;
            end
        end
        else begin
            if (sorted_count == 0) begin
                resp.status = ST_EMPTY;
            end
            else begin
                pos = -1;
                for (int j = 0; j < sorted_count; j++)
                begin
                    if (pos < 0 && sorted_entries[j] == v)
                        pos = j;
                end
                if (pos < 0) begin
                    resp.status = ST_NOT_FOUND;
                end
                else begin
                    for (int j = pos; j < sorted_count - 1; j++)
                    begin
                        sorted_entries[j] = sorted_entries[j+1];
                    end
                    sorted_count--;
                    resp.status = ST_DONE;
                end
            end
        end
        resp.count = sorted_count[ENTRY_COUNT_W-1:0];
        resp.head  = (sorted_count > 0) ? sorted_entries[0] : '0;
        return resp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        queue_response_t want;
        if (!rst_n) begin
            sorted_count = 0;
            expected_responses.delete();
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_responses.size() == 0) begin
                    $display("%0t: response with no request outstanding: status %0d count %0d head %0d",
                             $time, status, entry_count, head_value);
                    error_total++;
                end
                else begin
                    want = expected_responses.pop_front();
                    if (status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                        error_total++;
                    end
                    if (entry_count !== want.count) begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.count, entry_count);
                        error_total++;
                    end
                    if (head_value !== want.head) begin
                        $display("%0t: head_value expected %0d, got %0d",
                                 $time, want.head, head_value);
                        error_total++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_responses.push_back(apply_request(req_type, value));
        end
        pending_count <= expected_responses.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 1100;
    localparam int PHASE_LEN   = 137;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_CYCLES  = 400000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    req_type_t                req_type  = REQ_INSERT;
    data_t                    value     = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    status_t                  status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    data_t                    head_value;

    logic  calm     = 1'b0;
    logic  hold_rsp = 1'b0;
    int    fail_count;
    int    pending_count;
    int    cycle_count = 0;
    data_t recent_inserts [64];
    int    recent_wr = 0;

    always #5 clk = ~clk;

    sorted_priority_queue #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .entry_count (entry_count),
        .head_value  (head_value)
    );

    spq_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .entry_count   (entry_count),
        .head_value    (head_value),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("[sorted_priority_queue] ERROR");
            $finish;
        end
    end

    // Response side: random back-pressure, one long hold-off, and a calm stretch.
    initial
    begin
        int held;
        held = 0;
        forever begin
            @(posedge clk);
            if (hold_rsp && held < HOLD_CYCLES) begin
                rsp_ready <= 1'b0;
                held++;
            end
            else if (calm)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Deletes often reuse a recently inserted value so that they find a match.
    function automatic data_t pick_value(input req_type_t kind);
        int sel;
        sel = $urandom_range(0, 99);
        if (kind == REQ_DELETE && sel < 45)
            return recent_inserts[$urandom_range(0, 63)];
        if (sel < 70)
            return data_t'(int'($urandom_range(0, 16)) - 8);
        if (sel < 80) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return '0;
                default: return '1;
            endcase
        end
        return data_t'($urandom());
    endfunction

    task automatic send_request(input req_type_t kind, input data_t v);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        value     <= v;
        if (kind == REQ_INSERT) begin
            recent_inserts[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 64;
        end
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int        insert_pct;
        req_type_t kind;
        for (int i = 0; i < 64; i++)
        begin
            recent_inserts[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: delete from an empty queue, extremes, duplicates, misses.
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, 32'sh7FFF_FFFF);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_DELETE, 32'sd7);
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_DELETE, 32'sh8000_0000);
        send_request(REQ_DELETE, 32'sh7FFF_FFFF);
        send_request(REQ_DELETE, 32'sh8000_0000);
        send_request(REQ_DELETE, -32'sd1);
        send_request(REQ_DELETE, '0);
        send_request(REQ_DELETE, 32'sd1);
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_DELETE, 32'sd5);

        // Alternate insert-heavy phases that fill the queue with delete-heavy
        // phases that drain it.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            insert_pct = ((n / PHASE_LEN) % 2 == 0) ? 80 : 15;
            if (n == 300)
                hold_rsp <= 1'b1;
            if (n == 550)
                calm <= 1'b1;
            if (n == 750)
                calm <= 1'b0;
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
            send_request(kind, pick_value(kind));
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
